// File: rtl/ssaf_pkg.sv
// ----------------------------------------------------------------------------
// ssaf_pkg
// Types and constants shared by the steering force pipeline.
// ----------------------------------------------------------------------------
package ssaf_pkg;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               was_clamped;
    logic               zero_direction;
  } out_word_t;

  typedef struct packed {
    logic [30:0] max_speed;
    logic [30:0] max_force;
    logic [30:0] arrive_distance;
  } cfg_t;

  localparam logic [1:0] REG_MAX_SPEED = 2'd0;
  localparam logic [1:0] REG_MAX_FORCE = 2'd1;
  localparam logic [1:0] REG_ARRIVE    = 2'd2;

  localparam logic [30:0] MAX_SPEED_RST = 31'd65536;
  localparam logic [30:0] MAX_FORCE_RST = 31'd65536;
  localparam logic [30:0] ARRIVE_RST    = 31'd655360;

  // Signed shift: positive moves left.
  typedef logic signed [6:0] shamt_t;

  // Common shift bringing m into [2^30, 2^31).
  function automatic shamt_t norm_shift(input logic [33:0] m);
    shamt_t s;
    s = 7'sd0;
    for (int b = 0; b < 34; b++) begin
      if (m[b]) s = shamt_t'(30 - b);
    end
    return s;
  endfunction

  function automatic logic [63:0] apply_shift(input logic [63:0] v, input shamt_t s);
    logic [63:0] r;
    if (s >= 0) r = v << s;
    else r = v >> (-s);
    return r;
  endfunction

endpackage

// File: rtl/ssaf_sqrt.sv
// ----------------------------------------------------------------------------
// ssaf_sqrt
// Pipelined integer square root, two result bits per stage, payload travels.
// ----------------------------------------------------------------------------
module ssaf_sqrt #(
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [63:0]   in_x,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [31:0]   out_root,
  output logic [PW-1:0] out_pay
);
  localparam int NS = 16;

  logic [NS:0]   vld;
  logic [63:0]   rem [NS+1];
  logic [63:0]   res [NS+1];
  logic [PW-1:0] pay [NS+1];

  always_comb begin
    vld[0] = in_valid;
    rem[0] = in_x;
    res[0] = '0;
    pay[0] = in_pay;
  end

  for (genvar g = 0; g < NS; g++) begin : g_st
    logic [63:0] bitv, rem_n, res_n;
    always_comb begin
      rem_n = rem[g];
      res_n = res[g];
      bitv  = '0;
      for (int k = 0; k < 2; k++) begin
        bitv = 64'd1 << (62 - 4 * g - 2 * k);
        if (rem_n >= res_n + bitv) begin
          rem_n = rem_n - (res_n + bitv);
          res_n = (res_n >> 1) + bitv;
        end else begin
          res_n = res_n >> 1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) vld[g+1] <= 1'b0;
      else vld[g+1] <= vld[g];
      rem[g+1] <= rem_n;
      res[g+1] <= res_n;
      pay[g+1] <= pay[g];
    end
  end

  assign out_valid = vld[NS];
  assign out_root  = res[NS][31:0];
  assign out_pay   = pay[NS];
endmodule

// File: rtl/ssaf_div.sv
// ----------------------------------------------------------------------------
// ssaf_div
// Pipelined restoring divider, 64 by 32 bits, quotient kept to 32 bits.
// Four quotient bits per stage.
// ----------------------------------------------------------------------------
module ssaf_div #(
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [63:0]   in_num,
  input  logic [31:0]   in_den,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [31:0]   out_quo,
  output logic [PW-1:0] out_pay
);
  localparam int NS = 16;

  logic [NS:0]   vld;
  logic [63:0]   num [NS+1];
  logic [32:0]   rmd [NS+1];
  logic [31:0]   den [NS+1];
  logic [63:0]   quo [NS+1];
  logic [PW-1:0] pay [NS+1];

  always_comb begin
    vld[0] = in_valid;
    num[0] = in_num;
    rmd[0] = '0;
    den[0] = in_den;
    quo[0] = '0;
    pay[0] = in_pay;
  end

  for (genvar g = 0; g < NS; g++) begin : g_st
    logic [32:0] r;
    logic [63:0] n, q;
    always_comb begin
      r = rmd[g];
      n = num[g];
      q = quo[g];
      for (int k = 0; k < 4; k++) begin
        r = {r[31:0], n[63]};
        n = n << 1;
        q = q << 1;
        if (r >= {1'b0, den[g]}) begin
          r = r - {1'b0, den[g]};
          q[0] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) vld[g+1] <= 1'b0;
      else vld[g+1] <= vld[g];
      num[g+1] <= n;
      rmd[g+1] <= r;
      den[g+1] <= den[g];
      quo[g+1] <= q;
      pay[g+1] <= pay[g];
    end
  end

  assign out_valid = vld[NS];
  assign out_quo   = quo[NS][31:0];
  assign out_pay   = pay[NS];
endmodule

// File: rtl/steering_seek_arrive_force.sv
// ----------------------------------------------------------------------------
// steering_seek_arrive_force
// Seek / arrive steering force with magnitude clamp, fully pipelined.
//
//  channel   handshake          payload
//  command   start, busy        cmd  (in_word_t)
//  result    done               res  (out_word_t)
//  config    APB write / read   paddr, pwdata, prdata
//
// One word enters per cycle; busy stays low. Done rises once a word has
// passed two square root and three divider pipelines of 16 stages each in
// series plus twelve single stages.
// Reset clears all valid bits and loads register defaults.
// The receiver cannot stall; results leave on done for one cycle.
// ----------------------------------------------------------------------------
module steering_seek_arrive_force #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ssaf_pkg::in_word_t cmd,
  output logic               done,
  output ssaf_pkg::out_word_t res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  localparam int OB = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam logic signed [33:0] SAT_HI = 34'sd1 <<< (OB - 1);
  // FRAC_BITS does not change any step; every step is a ratio of like units.
  localparam int FB_UNUSED = FRAC_BITS;

  ssaf_pkg::cfg_t cfg;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_speed       <= ssaf_pkg::MAX_SPEED_RST;
      cfg.max_force       <= ssaf_pkg::MAX_FORCE_RST;
      cfg.arrive_distance <= ssaf_pkg::ARRIVE_RST;
    end else if (psel && penable && pwrite && FB_UNUSED >= 0) begin
      unique case (paddr[3:2])
        ssaf_pkg::REG_MAX_SPEED: cfg.max_speed       <= pwdata[30:0];
        ssaf_pkg::REG_MAX_FORCE: cfg.max_force       <= pwdata[30:0];
        ssaf_pkg::REG_ARRIVE:    cfg.arrive_distance <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ssaf_pkg::REG_MAX_SPEED: prdata = {1'b0, cfg.max_speed};
      ssaf_pkg::REG_MAX_FORCE: prdata = {1'b0, cfg.max_force};
      ssaf_pkg::REG_ARRIVE:    prdata = {1'b0, cfg.arrive_distance};
      default:                 prdata = '0;
    endcase
  end

  // Payload carried along the direction path.
  typedef struct packed {
    logic               mode;
    logic               zero;
    logic               nx;
    logic               ny;
    logic [63:0]        ax;
    logic [63:0]        ay;
    ssaf_pkg::shamt_t   s;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [31:0]        len;
    logic [31:0]        spd;
  } dir_t;
  localparam int DW = $bits(dir_t);

  // ---- stage A: offset
  logic               a_v;
  logic signed [32:0] a_dx, a_dy;
  ssaf_pkg::in_word_t a_c;
  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else a_v <= start;
    a_c  <= cmd;
    a_dx <= 33'(cmd.goal_x) - 33'(cmd.pos_x);
    a_dy <= 33'(cmd.goal_y) - 33'(cmd.pos_y);
  end

  // ---- stage B: magnitudes and shift
  logic       b_v;
  dir_t       b_d;
  logic [33:0] b_mx, b_my;
  always_comb begin
    b_mx = a_dx[32] ? 34'(-35'(a_dx)) : 34'(a_dx);
    b_my = a_dy[32] ? 34'(-35'(a_dy)) : 34'(a_dy);
  end
  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else b_v <= a_v;
    b_d.mode <= a_c.mode;
    b_d.zero <= (a_dx == 0) && (a_dy == 0);
    b_d.nx   <= a_dx[32];
    b_d.ny   <= a_dy[32];
    b_d.s    <= ssaf_pkg::norm_shift(b_mx > b_my ? b_mx : b_my);
    b_d.ax   <= 64'(b_mx);
    b_d.ay   <= 64'(b_my);
    b_d.vx   <= a_c.vel_x;
    b_d.vy   <= a_c.vel_y;
    b_d.vz   <= a_c.vel_z;
    b_d.len  <= '0;
    b_d.spd  <= '0;
  end

  // ---- stage C: shift
  logic c_v;
  dir_t c_d;
  dir_t c_d_next;
  always_comb begin
    c_d_next    = b_d;
    c_d_next.ax = ssaf_pkg::apply_shift(b_d.ax, b_d.s);
    c_d_next.ay = ssaf_pkg::apply_shift(b_d.ay, b_d.s);
  end
  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else c_v <= b_v;
    c_d <= c_d_next;
  end

  // ---- stage D: squares
  logic        d_v;
  dir_t        d_d;
  logic [63:0] d_sq;
  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else d_v <= c_v;
    d_d  <= c_d;
    d_sq <= c_d.ax[31:0] * c_d.ax[31:0] + c_d.ay[31:0] * c_d.ay[31:0];
  end

  logic        e_v;
  logic [31:0] e_len;
  dir_t        e_p;
  ssaf_sqrt #(.PW(DW)) u_sqrt_dir (
    .clk, .rst, .in_valid(d_v), .in_x(d_sq), .in_pay(d_d),
    .out_valid(e_v), .out_root(e_len), .out_pay(e_p)
  );

  // ---- stage F: distance and speed numerator
  logic        f_v, f_slow;
  dir_t        f_d;
  dir_t        f_d_next;
  logic [63:0] f_dist;
  always_comb begin
    f_dist       = ssaf_pkg::apply_shift(64'(e_len), -e_p.s);
    f_d_next     = e_p;
    f_d_next.len = e_len;
  end
  logic [63:0] g_num;
  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else f_v <= e_v;
    f_d     <= f_d_next;
    f_slow  <= e_p.mode && (f_dist < 64'(cfg.arrive_distance));
    g_num   <= 64'(cfg.max_speed) * 64'(f_dist[31:0]);
  end

  logic [31:0] h_q;
  logic        h_v;
  logic [DW:0] h_p;
  ssaf_div #(.PW(DW + 1)) u_div_spd (
    .clk, .rst, .in_valid(f_v), .in_num(g_num),
    .in_den({1'b0, cfg.arrive_distance}), .in_pay({f_slow, f_d}),
    .out_valid(h_v), .out_quo(h_q), .out_pay(h_p)
  );

  // ---- stage I: speed, scaled components
  logic        i_v;
  dir_t        i_d;
  logic [63:0] i_nx, i_ny;
  always_comb begin
    i_d     = h_p[DW-1:0];
    i_d.spd = h_p[DW] ? h_q : {1'b0, cfg.max_speed};
  end
  dir_t i_dr;
  always_ff @(posedge clk) begin
    if (rst) i_v <= 1'b0;
    else i_v <= h_v;
    i_dr <= i_d;
    i_nx <= i_d.ax[31:0] * i_d.spd;
    i_ny <= i_d.ay[31:0] * i_d.spd;
  end

  logic [31:0] j_qx, j_qy;
  logic        j_v, j_v2;
  dir_t        j_d, j_d2;
  ssaf_div #(.PW(DW)) u_div_x (
    .clk, .rst, .in_valid(i_v), .in_num(i_nx), .in_den(i_dr.zero ? 32'd1 : i_dr.len),
    .in_pay(i_dr), .out_valid(j_v), .out_quo(j_qx), .out_pay(j_d)
  );
  ssaf_div #(.PW(DW)) u_div_y (
    .clk, .rst, .in_valid(i_v), .in_num(i_ny), .in_den(i_dr.zero ? 32'd1 : i_dr.len),
    .in_pay(i_dr), .out_valid(j_v2), .out_quo(j_qy), .out_pay(j_d2)
  );

  // ---- stage K: raw force
  logic               k_v, k_zero;
  logic signed [33:0] k_f [3];
  always_ff @(posedge clk) begin
    if (rst) k_v <= 1'b0;
    else k_v <= j_v && j_v2;
    k_zero <= j_d2.zero;
    k_f[0] <= (j_d.zero ? 34'sd0 : (j_d.nx ? -34'(j_qx) : 34'(j_qx))) - 34'(j_d.vx);
    k_f[1] <= (j_d.zero ? 34'sd0 : (j_d.ny ? -34'(j_qy) : 34'(j_qy))) - 34'(j_d.vy);
    k_f[2] <= -34'(j_d.vz);
  end

  // Force payload.
  typedef struct packed {
    logic               zero;
    logic [2:0]         neg;
    logic [33:0]        m0;
    logic [33:0]        m1;
    logic [33:0]        m2;
    logic [33:0]        mx;
    ssaf_pkg::shamt_t   s;
    logic [31:0]        a0;
    logic [31:0]        a1;
    logic [31:0]        a2;
    logic               clamp;
    logic [31:0]        len;
  } frc_t;
  localparam int FW = $bits(frc_t);

  // ---- stage L: magnitudes
  logic l_v;
  frc_t l_d;
  always_comb begin : l_mag
    logic [33:0] m0, m1, m2, mx;
    m0 = k_f[0][33] ? 34'(-k_f[0]) : 34'(k_f[0]);
    m1 = k_f[1][33] ? 34'(-k_f[1]) : 34'(k_f[1]);
    m2 = k_f[2][33] ? 34'(-k_f[2]) : 34'(k_f[2]);
    mx = m0;
    if (m1 > mx) mx = m1;
    if (m2 > mx) mx = m2;
    l_d       = '0;
    l_d.zero  = k_zero;
    l_d.neg   = {k_f[2][33], k_f[1][33], k_f[0][33]};
    l_d.m0    = m0;
    l_d.m1    = m1;
    l_d.m2    = m2;
    l_d.mx    = mx;
    l_d.s     = ssaf_pkg::norm_shift(mx);
  end
  frc_t l_r;
  always_ff @(posedge clk) begin
    if (rst) l_v <= 1'b0;
    else l_v <= k_v;
    l_r <= l_d;
  end

  // ---- stage M: shifted components and exact squares
  logic        m_v;
  frc_t        m_r;
  frc_t        m_r_next;
  logic [68:0] m_s0, m_s1, m_s2;
  logic [63:0] m_ff;
  always_comb begin
    m_r_next    = l_r;
    m_r_next.a0 = 32'(ssaf_pkg::apply_shift(64'(l_r.m0), l_r.s));
    m_r_next.a1 = 32'(ssaf_pkg::apply_shift(64'(l_r.m1), l_r.s));
    m_r_next.a2 = 32'(ssaf_pkg::apply_shift(64'(l_r.m2), l_r.s));
  end
  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else m_v <= l_v;
    m_r    <= m_r_next;
    m_s0   <= 69'(l_r.m0) * 69'(l_r.m0);
    m_s1   <= 69'(l_r.m1) * 69'(l_r.m1);
    m_s2   <= 69'(l_r.m2) * 69'(l_r.m2);
    m_ff   <= 64'(cfg.max_force) * 64'(cfg.max_force);
  end

  // ---- stage N: clamp decision, squares of shifted values
  logic        n_v;
  frc_t        n_r;
  frc_t        n_r_next;
  logic [63:0] n_sq;
  always_comb begin
    n_r_next       = m_r;
    n_r_next.clamp = (m_r.mx > 34'(cfg.max_force)) ||
                     ((70'(m_s0) + 70'(m_s1) + 70'(m_s2)) > 70'(m_ff));
  end
  always_ff @(posedge clk) begin
    if (rst) n_v <= 1'b0;
    else n_v <= m_v;
    n_r       <= n_r_next;
    n_sq      <= 64'(m_r.a0) * 64'(m_r.a0) + 64'(m_r.a1) * 64'(m_r.a1)
               + 64'(m_r.a2) * 64'(m_r.a2);
  end

  logic        o_v;
  logic [31:0] o_len;
  frc_t        o_p;
  ssaf_sqrt #(.PW(FW)) u_sqrt_frc (
    .clk, .rst, .in_valid(n_v), .in_x(n_sq), .in_pay(n_r),
    .out_valid(o_v), .out_root(o_len), .out_pay(o_p)
  );

  // ---- stage P: clamp numerators
  logic        p_v;
  frc_t        p_r;
  frc_t        p_r_next;
  logic [63:0] p_n0, p_n1, p_n2;
  always_comb begin
    p_r_next     = o_p;
    p_r_next.len = (o_len == 0) ? 32'd1 : o_len;
  end
  always_ff @(posedge clk) begin
    if (rst) p_v <= 1'b0;
    else p_v <= o_v;
    p_r     <= p_r_next;
    p_n0    <= 64'(o_p.a0) * 64'(cfg.max_force);
    p_n1    <= 64'(o_p.a1) * 64'(cfg.max_force);
    p_n2    <= 64'(o_p.a2) * 64'(cfg.max_force);
  end

  logic [31:0] q0, q1, q2;
  logic        qv0, qv1, qv2;
  frc_t        qp0, qp1, qp2;
  ssaf_div #(.PW(FW)) u_div_c0 (
    .clk, .rst, .in_valid(p_v), .in_num(p_n0), .in_den(p_r.len), .in_pay(p_r),
    .out_valid(qv0), .out_quo(q0), .out_pay(qp0)
  );
  ssaf_div #(.PW(FW)) u_div_c1 (
    .clk, .rst, .in_valid(p_v), .in_num(p_n1), .in_den(p_r.len), .in_pay(p_r),
    .out_valid(qv1), .out_quo(q1), .out_pay(qp1)
  );
  ssaf_div #(.PW(FW)) u_div_c2 (
    .clk, .rst, .in_valid(p_v), .in_num(p_n2), .in_den(p_r.len), .in_pay(p_r),
    .out_valid(qv2), .out_quo(q2), .out_pay(qp2)
  );

  function automatic logic signed [31:0] sat(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI - 34'sd1) r = 32'(SAT_HI - 34'sd1);
    else if (v < -SAT_HI) r = 32'(-SAT_HI);
    else r = 32'(v);
    return r;
  endfunction

  function automatic logic signed [33:0] pick(input logic c, input logic n,
                                              input logic [31:0] q, input logic [33:0] m);
    logic signed [33:0] r;
    if (c) r = n ? -34'(q) : 34'(q);
    else r = n ? -34'(m) : 34'(m);
    return r;
  endfunction

  // ---- output register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= qv0 && qv1 && qv2;
    res.force_x        <= sat(pick(qp0.clamp, qp0.neg[0], q0, qp0.m0));
    res.force_y        <= sat(pick(qp1.clamp, qp1.neg[1], q1, qp1.m1));
    res.force_z        <= sat(pick(qp2.clamp, qp2.neg[2], q2, qp2.m2));
    res.was_clamped    <= qp0.clamp;
    res.zero_direction <= qp0.zero;
  end

`ifndef NO_ASSERTIONS
  a_lanes: assert property (@(posedge clk) disable iff (rst) qv0 == qv1 && qv1 == qv2)
    else $error("divider lanes out of step");
  a_dir_lanes: assert property (@(posedge clk) disable iff (rst) j_v == j_v2)
    else $error("direction lanes out of step");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    done && res.was_clamped && cfg.max_force == 0 |->
    res.force_x == 0 && res.force_y == 0 && res.force_z == 0)
    else $error("zero limit gave nonzero force");
`endif
endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives agents into the steering force pipeline with random gaps, rewrites
// the speed, force and slowing-radius registers between phases, and checks
// every force word against a bit-exact predictor in a small scoreboard.
// ----------------------------------------------------------------------------

class force_scoreboard;
  ssaf_pkg::out_word_t pending[$];
  ssaf_pkg::cfg_t      cfg;
  int                  errors;

  function new();
    cfg.max_speed       = ssaf_pkg::MAX_SPEED_RST;
    cfg.max_force       = ssaf_pkg::MAX_FORCE_RST;
    cfg.arrive_distance = ssaf_pkg::ARRIVE_RST;
    errors = 0;
  endfunction

  static function int shift_for(logic [63:0] m);
    int s;
    s = 0;
    if (m == 0) return 0;
    while (m < 64'h4000_0000) begin m = m << 1; s++; end
    while (m >= 64'h8000_0000) begin m = m >> 1; s--; end
    return s;
  endfunction

  static function logic [63:0] shifted(logic [63:0] v, int s);
    if (s >= 0) return v << s;
    return v >> (-s);
  endfunction

  static function logic [63:0] root_floor(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  static function logic [63:0] absval(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function ssaf_pkg::out_word_t steer(ssaf_pkg::in_word_t c);
    ssaf_pkg::out_word_t o;
    longint dx, dy, desx, desy;
    longint f[3];
    logic [63:0] ax, ay, len, reach, spd, mx;
    logic [63:0] m[3], a[3];
    logic [63:0] mf;
    int s;
    bit clamp;
    dx = longint'(c.goal_x) - longint'(c.pos_x);
    dy = longint'(c.goal_y) - longint'(c.pos_y);
    desx = 0;
    desy = 0;
    if (!(dx == 0 && dy == 0)) begin
      ax = absval(dx);
      ay = absval(dy);
      s = shift_for(ax > ay ? ax : ay);
      ax = shifted(ax, s);
      ay = shifted(ay, s);
      len = root_floor(ax * ax + ay * ay);
      reach = (s >= 0) ? (len >> s) : (len << (-s));
      spd = cfg.max_speed;
      if (c.mode && reach < cfg.arrive_distance)
        spd = (spd * reach) / cfg.arrive_distance;
      desx = longint'((ax * spd) / len);
      desy = longint'((ay * spd) / len);
      if (dx < 0) desx = -desx;
      if (dy < 0) desy = -desy;
    end
    f[0] = desx - longint'(c.vel_x);
    f[1] = desy - longint'(c.vel_y);
    f[2] = -longint'(c.vel_z);
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = absval(f[i]);
      if (m[i] > mx) mx = m[i];
    end
    mf = cfg.max_force;
    clamp = (mx > mf) || (m[0] * m[0] + m[1] * m[1] + m[2] * m[2] > mf * mf);
    if (clamp) begin
      s = shift_for(mx);
      for (int i = 0; i < 3; i++) a[i] = shifted(m[i], s);
      len = root_floor(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
      for (int i = 0; i < 3; i++) begin
        if (f[i] < 0) f[i] = -longint'((a[i] * mf) / len);
        else f[i] = longint'((a[i] * mf) / len);
      end
    end
    o.force_x = f[0][31:0];
    o.force_y = f[1][31:0];
    o.force_z = f[2][31:0];
    o.was_clamped = clamp;
    o.zero_direction = (dx == 0 && dy == 0);
    return o;
  endfunction

  function void note_agent(ssaf_pkg::in_word_t c);
    pending.push_back(steer(c));
  endfunction

  task mismatch(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task check_force(ssaf_pkg::out_word_t got);
    ssaf_pkg::out_word_t exp_w;
    if (pending.size() == 0) begin
      mismatch("force word with nothing pending");
      return;
    end
    exp_w = pending.pop_front();
    if (got.force_x !== exp_w.force_x)
      mismatch($sformatf("force_x %h want %h", got.force_x, exp_w.force_x));
    if (got.force_y !== exp_w.force_y)
      mismatch($sformatf("force_y %h want %h", got.force_y, exp_w.force_y));
    if (got.force_z !== exp_w.force_z)
      mismatch($sformatf("force_z %h want %h", got.force_z, exp_w.force_z));
    if (got.was_clamped !== exp_w.was_clamped)
      mismatch($sformatf("was_clamped %b want %b", got.was_clamped, exp_w.was_clamped));
    if (got.zero_direction !== exp_w.zero_direction)
      mismatch($sformatf("zero_direction %b want %b", got.zero_direction,
                         exp_w.zero_direction));
  endtask
endclass

module testbench;
  localparam int LATENCY = 200;
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  ssaf_pkg::in_word_t  cmd = '0;
  logic                done;
  ssaf_pkg::out_word_t res;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  force_scoreboard board;

  steering_seek_arrive_force u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .res(res), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_force(res);
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    // out-of-range indexes are dropped by the block
    if (idx == ssaf_pkg::REG_MAX_SPEED) board.cfg.max_speed = val[30:0];
    else if (idx == ssaf_pkg::REG_MAX_FORCE) board.cfg.max_force = val[30:0];
    else if (idx == ssaf_pkg::REG_ARRIVE) board.cfg.arrive_distance = val[30:0];
  endtask

  // start stays high between back-to-back words; drop it only for a gap
  task automatic send_agent(ssaf_pkg::in_word_t c, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    board.note_agent(c);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'h7fff_ffff - $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic ssaf_pkg::in_word_t rnd_agent();
    ssaf_pkg::in_word_t c;
    c.mode = 1'($urandom);
    c.pos_x = rnd_coord(); c.pos_y = rnd_coord();
    c.goal_x = rnd_coord(); c.goal_y = rnd_coord();
    c.vel_x = rnd_coord(); c.vel_y = rnd_coord(); c.vel_z = rnd_coord();
    if ($urandom_range(0, 9) == 0) begin
      c.goal_x = c.pos_x; c.goal_y = c.pos_y;
    end
    if ($urandom_range(0, 4) == 0) begin
      c.vel_x = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      c.vel_y = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      c.vel_z = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
    end
    return c;
  endfunction

  function automatic ssaf_pkg::in_word_t agent(bit md, logic [31:0] px, logic [31:0] py,
                                               logic [31:0] gx, logic [31:0] gy,
                                               logic [31:0] vx, logic [31:0] vy,
                                               logic [31:0] vz);
    ssaf_pkg::in_word_t c;
    c.mode = md; c.pos_x = px; c.pos_y = py; c.goal_x = gx; c.goal_y = gy;
    c.vel_x = vx; c.vel_y = vy; c.vel_z = vz;
    return c;
  endfunction

  initial begin
    #2000000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [31:0] mn, mp;
    board = new();
    mn = 32'h8000_0000;
    mp = 32'h7fff_ffff;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults first, then a few register extremes
    send_agent(agent(0, 0, 0, 32'h50000, 0, 0, 0, 0), 0);
    send_agent(agent(1, 0, 0, 32'h30000, 32'h40000, 0, 0, 0), 0);
    send_agent(agent(1, 5, 7, 5, 7, 32'h100, 0, 0), 1);
    send_agent(agent(0, 5, 7, 5, 7, 0, 0, 0), 0);
    send_agent(agent(0, mn, mn, mp, mp, mp, mn, mn), 0);
    send_agent(agent(1, mp, mp, mn, mn, mn, mp, mp), 2);
    send_agent(agent(1, 0, 0, 1, 0, 0, 0, 0), 0);
    send_agent(agent(0, 0, 0, 0, 32'hffff_ffff, 0, 0, 32'hffff_ffff), 0);
    drain();
    write_reg(ssaf_pkg::REG_MAX_FORCE, 32'h0);
    write_reg(ssaf_pkg::REG_ARRIVE, 32'h0);
    write_reg(ssaf_pkg::REG_MAX_SPEED, 32'hffff_ffff);
    send_agent(agent(1, 0, 0, 32'h10000, 0, 0, 0, 0), 0);
    send_agent(agent(0, 0, 0, 0, 0, 0, 0, 0), 0);
    send_agent(agent(1, 3, 3, 3, 3, 1, 0, 0), 0);
    send_agent(agent(0, mn, 0, mp, 0, mn, mp, mn), 0);
    drain();
    write_reg(ssaf_pkg::REG_MAX_FORCE, 32'h7fff_ffff);
    write_reg(ssaf_pkg::REG_ARRIVE, 32'hffff_ffff);
    send_agent(agent(1, 0, 0, 32'h1234_5678, 32'h0abc_def0, 0, 0, 0), 0);
    send_agent(agent(1, mn, mn, mp, mp, 0, 0, 0), 0);
    send_agent(agent(0, mp, 0, mn, 0, mp, mp, mp), 0);
    send_agent(agent(1, 0, 0, 1, 1, mn, mn, mn), 0);
    drain();
    write_reg(REG_SPARE, 32'h1234);

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: begin
          write_reg(ssaf_pkg::REG_MAX_SPEED, 32'h10000);
          write_reg(ssaf_pkg::REG_MAX_FORCE, 32'h10000);
          write_reg(ssaf_pkg::REG_ARRIVE, 32'ha0000);
        end
        1: begin
          write_reg(ssaf_pkg::REG_MAX_SPEED, 32'h7fff_ffff);
          write_reg(ssaf_pkg::REG_MAX_FORCE, 32'h7fff_ffff);
          write_reg(ssaf_pkg::REG_ARRIVE, 32'h1);
        end
        default: begin
          write_reg(ssaf_pkg::REG_MAX_SPEED, $urandom);
          write_reg(ssaf_pkg::REG_MAX_FORCE,
                    ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 32'h40000));
          write_reg(ssaf_pkg::REG_ARRIVE,
                    ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 32'h0fff_ffff));
        end
      endcase
      for (int n = 0; n < 250; n++) begin
        // long run of back-to-back words now and then
        send_agent(rnd_agent(), (n % 60 < 20) ? 0 : $urandom_range(0, 5));
        if (n == 125) drain();
      end
    end
    drain();
    if (board.pending.size() == 0 && board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
